// ===== hw/rtl/plti_pkg.sv =====
// shared types and constants for the piecewise-linear table interpolator
`default_nettype none
package plti_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int FRAC_W      = 16;

  // input operations
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_POS   = 2'd1;
  localparam logic [1:0] ST_NOT_INCR  = 2'd2;
  localparam logic [1:0] ST_IDX_RANGE = 2'd3;

  // lookup region codes
  localparam logic [1:0] RG_INSIDE = 2'd0;
  localparam logic [1:0] RG_BELOW  = 2'd1;
  localparam logic [1:0] RG_ABOVE  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ENTRY_COUNT = 2'd0;
  localparam logic [1:0] CFG_OMEGA_MIN   = 2'd1;
  localparam logic [1:0] CFG_BELOW_ZERO  = 2'd2;
  localparam logic [1:0] CFG_ABOVE_ZERO  = 2'd3;

  typedef struct packed {
    logic               op;
    logic [5:0]         entry_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_out;
    logic [1:0]         status;
    logic [1:0]         region;
  } out_item_t;

endpackage
`default_nettype wire

// ===== hw/rtl/plti_div.sv =====
// iterative restoring divider giving a 16-bit fraction num/den with num < den
`default_nettype none
module plti_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [32:0]               num,
  input  wire logic [32:0]               den,
  output logic                           done,
  output logic [plti_pkg::FRAC_W-1:0]    quot
);

  logic [32:0]                  rem_r, rem_nxt;
  logic [32:0]                  den_r;
  logic [plti_pkg::FRAC_W-1:0]  quot_r, quot_nxt;
  logic [4:0]                   cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [33:0]                  shifted;

  always_comb begin
    shifted  = {rem_r, 1'b0};
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      quot_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one quotient bit a cycle; the remainder stays below den
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt  = 33'(shifted - {1'b0, den_r});
        quot_nxt = {quot_r[plti_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[32:0];
        quot_nxt = {quot_r[plti_pkg::FRAC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(plti_pkg::FRAC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule
`default_nettype wire

// ===== hw/rtl/piecewise_linear_table_interp_core.sv =====
// top level of the piecewise-linear table interpolator
`default_nettype none
// Holds up to 64 (x, y) points in two synchronous memories, each with one read
// port, and handles one item at a time. A load does one memory read of the
// previous x for the ordering check, then the write. A lookup reads the first
// and last points (2 reads), and for an argument inside the table runs a binary
// search of up to 6 memory reads, reads the bracketing pair, then waits on the
// bit-serial divider for the fraction (16 quotient bits and its done flag),
// then passes through the multiplier and the final add and floor. The result
// sits in an output register, so the next item is taken as soon as the block
// is back in idle, even while the result waits.
// Table entries read before they were ever written give undefined results.
module piecewise_linear_table_interp_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire plti_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output plti_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LD_RD  = 4'd1;
  localparam logic [3:0] S_LD_CHK = 4'd2;
  localparam logic [3:0] S_LK0    = 4'd3;
  localparam logic [3:0] S_LK1    = 4'd4;
  localparam logic [3:0] S_LK2    = 4'd5;
  localparam logic [3:0] S_SRCH   = 4'd6;
  localparam logic [3:0] S_SRCH_W = 4'd7;
  localparam logic [3:0] S_RLO    = 4'd8;
  localparam logic [3:0] S_RHI    = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_MUL    = 4'd11;
  localparam logic [3:0] S_ADD    = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  localparam int AW = plti_pkg::ADDR_W;

  // configuration
  logic [plti_pkg::CNT_W-1:0] entry_count_r;
  logic signed [31:0]         omega_min_r;
  logic                       below_zero_r;
  logic                       above_zero_r;

  // table memories
  logic signed [31:0] x_mem [plti_pkg::TABLE_DEPTH];
  logic signed [31:0] y_mem [plti_pkg::TABLE_DEPTH];
  logic signed [31:0] x_rd_r, y_rd_r;
  logic [AW-1:0]      raddr;
  logic               mem_we;
  logic signed [31:0] y_wr;

  logic [3:0]          state_r, state_nxt;
  plti_pkg::in_item_t  item_r;
  logic signed [31:0]  xq_r, xq_nxt;
  logic [AW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [31:0]  xlo_r, xlo_nxt, ylo_r, ylo_nxt;
  logic signed [32:0]  dy_r, dy_nxt;
  logic signed [49:0]  prod_r, prod_nxt;
  plti_pkg::out_item_t res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  plti_pkg::out_item_t out_item_r, out_item_nxt;

  logic [plti_pkg::CNT_W-1:0] n_act;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              mid;
  logic                       in_acc;
  logic                       div_start, div_done;
  logic [plti_pkg::FRAC_W-1:0] quot;
  logic signed [32:0]         num_s, den_s;
  logic signed [34:0]         ysum;
  logic signed [34:0]         omega_ext;

  // count clamped to 2..depth
  always_comb begin
    if (entry_count_r < plti_pkg::CNT_W'(2)) begin
      n_act = plti_pkg::CNT_W'(2);
    end else if (entry_count_r > plti_pkg::CNT_W'(plti_pkg::TABLE_DEPTH)) begin
      n_act = plti_pkg::CNT_W'(plti_pkg::TABLE_DEPTH);
    end else begin
      n_act = entry_count_r;
    end
  end

  assign last_idx  = AW'(n_act - plti_pkg::CNT_W'(1));
  assign mid       = AW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign num_s     = 33'(xq_r) - 33'(xlo_r);
  assign den_s     = 33'(x_rd_r) - 33'(xlo_r);
  assign y_wr      = (item_r.y_value < omega_min_r) ? omega_min_r : item_r.y_value;
  assign ysum      = 35'(ylo_r) + 35'($signed(prod_r[49:16]));
  assign omega_ext = 35'(omega_min_r);

  plti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_s),
    .den   (den_s),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_nxt     = state_r;
    xq_nxt        = xq_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    xlo_nxt       = xlo_r;
    ylo_nxt       = ylo_r;
    dy_nxt        = dy_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    raddr         = '0;
    mem_we        = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt = '{y_out: '0, status: plti_pkg::ST_OK, region: plti_pkg::RG_INSIDE};
          xq_nxt  = in_item.x_value[31] ? '0 : in_item.x_value;
          if (in_item.op == plti_pkg::OP_LOOKUP) begin
            state_nxt = S_LK0;
          end else begin
            state_nxt = S_LD_RD;
          end
        end
      end
      S_LD_RD: begin
        // previous entry for the ordering check
        raddr = item_r.entry_index - AW'(1);
        if ({1'b0, item_r.entry_index} >= n_act) begin
          res_nxt.status = plti_pkg::ST_IDX_RANGE;
          state_nxt      = S_DONE;
        end else if (item_r.x_value <= 0) begin
          res_nxt.status = plti_pkg::ST_NOT_POS;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_LD_CHK;
        end
      end
      S_LD_CHK: begin
        if (item_r.entry_index != '0 && item_r.x_value <= x_rd_r) begin
          res_nxt.status = plti_pkg::ST_NOT_INCR;
        end else begin
          mem_we = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_LK0: begin
        raddr     = '0;
        state_nxt = S_LK1;
      end
      S_LK1: begin
        if (xq_r <= x_rd_r) begin
          res_nxt.region = plti_pkg::RG_BELOW;
          res_nxt.y_out  = below_zero_r ? '0 : y_rd_r;
          state_nxt      = S_DONE;
        end else begin
          raddr     = last_idx;
          state_nxt = S_LK2;
        end
      end
      S_LK2: begin
        if (xq_r >= x_rd_r) begin
          res_nxt.region = plti_pkg::RG_ABOVE;
          res_nxt.y_out  = above_zero_r ? '0 : y_rd_r;
          state_nxt      = S_DONE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = last_idx;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if ({1'b0, hi_r} - {1'b0, lo_r} > (AW+1)'(1)) begin
          raddr     = mid;
          state_nxt = S_SRCH_W;
        end else begin
          raddr     = lo_r;
          state_nxt = S_RLO;
        end
      end
      S_SRCH_W: begin
        if (x_rd_r <= xq_r) begin
          lo_nxt = mid;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRCH;
      end
      S_RLO: begin
        xlo_nxt   = x_rd_r;
        ylo_nxt   = y_rd_r;
        raddr     = hi_r;
        state_nxt = S_RHI;
      end
      S_RHI: begin
        dy_nxt    = 33'(y_rd_r) - 33'(ylo_r);
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = $signed({1'b0, quot}) * dy_r;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        // floor shift of the product, then floor at omega_min
        res_nxt.y_out = (ysum < omega_ext) ? omega_min_r : ysum[31:0];
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // memories: one read port, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[item_r.entry_index] <= item_r.x_value;
      y_mem[item_r.entry_index] <= y_wr;
    end
    x_rd_r <= x_mem[raddr];
    y_rd_r <= y_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= plti_pkg::CNT_W'(2);
      omega_min_r   <= '0;
      below_zero_r  <= 1'b0;
      above_zero_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          plti_pkg::CFG_ENTRY_COUNT: entry_count_r <= cfg_wdata[plti_pkg::CNT_W-1:0];
          plti_pkg::CFG_OMEGA_MIN:   omega_min_r   <= cfg_wdata;
          plti_pkg::CFG_BELOW_ZERO:  below_zero_r  <= cfg_wdata[0];
          plti_pkg::CFG_ABOVE_ZERO:  above_zero_r  <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    if (in_acc) begin
      item_r <= in_item;
    end
    xq_r       <= xq_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    xlo_r      <= xlo_nxt;
    ylo_r      <= ylo_nxt;
    dy_r       <= dy_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a load error never carries a lookup region or a value
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != plti_pkg::ST_OK |->
      out_item.region == plti_pkg::RG_INSIDE && out_item.y_out == '0)
    else $error("load error item carries lookup data");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside its wait state");

  // an accepted item always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not start");

  // table writes only come from a load
  a_we_load: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> item_r.op == plti_pkg::OP_LOAD && state_r == S_LD_CHK)
    else $error("table write outside a load");

endmodule
`default_nettype wire

// ===== bench/tb_piecewise_linear_table_interp_core.sv =====
// self-checking bench for the piecewise-linear table interpolator core
`timescale 1ns / 100ps
`default_nettype none
module tb_piecewise_linear_table_interp_core;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  plti_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  plti_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  piecewise_linear_table_interp_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: own copy of registers and table
  logic [6:0] cnt_reg;
  logic signed [31:0] floor_reg;
  logic below_reg, above_reg;
  logic signed [31:0] tab_x [plti_pkg::TABLE_DEPTH];
  logic signed [31:0] tab_y [plti_pkg::TABLE_DEPTH];
  bit written [plti_pkg::TABLE_DEPTH];

  plti_pkg::out_item_t pending_results[$];
  int n_mismatch = 0;
  bit hold_off = 1'b0;      // long receiver stall request

  function automatic int live_count();
    if (cnt_reg < 2) return 2;
    if (cnt_reg > plti_pkg::TABLE_DEPTH) return plti_pkg::TABLE_DEPTH;
    return cnt_reg;
  endfunction

  // predict result of one item and update the table copy
  function automatic plti_pkg::out_item_t interp_predict(plti_pkg::in_item_t it);
    plti_pkg::out_item_t r;
    longint xa, dx, num, frac, dy, prod, yy;
    int n, lo, hi, mid;
    r = '0;
    n = live_count();
    if (it.op == plti_pkg::OP_LOOKUP) begin
      xa = it.x_value;
      if (xa < 0) xa = 0;
      lo = 0;
      hi = n - 1;
      if (xa <= tab_x[0]) begin
        r.region = plti_pkg::RG_BELOW;
        r.y_out = below_reg ? 32'sd0 : tab_y[0];
      end else if (xa >= tab_x[hi]) begin
        r.region = plti_pkg::RG_ABOVE;
        r.y_out = above_reg ? 32'sd0 : tab_y[hi];
      end else begin
        r.region = plti_pkg::RG_INSIDE;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          if (tab_x[mid] <= xa) lo = mid;
          else hi = mid;
        end
        dx = longint'(tab_x[hi]) - tab_x[lo];
        num = xa - tab_x[lo];
        frac = (num <<< 16) / dx;
        dy = longint'(tab_y[hi]) - tab_y[lo];
        prod = frac * dy;
        // arithmetic shift floors toward minus infinity
        yy = longint'(tab_y[lo]) + (prod >>> 16);
        if (yy < floor_reg) yy = floor_reg;
        r.y_out = yy[31:0];
      end
    end else if (it.entry_index >= n) begin
      r.status = plti_pkg::ST_IDX_RANGE;
    end else if (it.x_value <= 0) begin
      r.status = plti_pkg::ST_NOT_POS;
    end else if (it.entry_index > 0 && it.x_value <= tab_x[it.entry_index - 1]) begin
      r.status = plti_pkg::ST_NOT_INCR;
    end else begin
      tab_x[it.entry_index] = it.x_value;
      tab_y[it.entry_index] = (it.y_value < floor_reg) ? floor_reg : it.y_value;
      written[it.entry_index] = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_mismatch++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      plti_pkg::CFG_ENTRY_COUNT: cnt_reg = val[6:0];
      plti_pkg::CFG_OMEGA_MIN:   floor_reg = val;
      plti_pkg::CFG_BELOW_ZERO:  below_reg = val[0];
      plti_pkg::CFG_ABOVE_ZERO:  above_reg = val[0];
      default: ;
    endcase
  endtask

  // offer one item with a random lead gap; optional typed-in expectation
  // valid stays up after acceptance until the next item or drain replaces it
  task automatic send_item(input plti_pkg::in_item_t it, input bit has_want,
                           input plti_pkg::out_item_t want);
    int gap;
    plti_pkg::out_item_t p;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = interp_predict(it);
    if (has_want && p != want)
      report_mismatch("directed row vs predictor", p, want);
    pending_results.push_back(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // receiver: random stalls, long hold-off on request
  initial begin
    int stall;
    plti_pkg::out_item_t e;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (hold_off) stall = 400;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_item, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_item.y_out !== e.y_out) report_mismatch("y_out", out_item.y_out, e.y_out);
        if (out_item.status !== e.status) report_mismatch("status", out_item.status, e.status);
        if (out_item.region !== e.region) report_mismatch("region", out_item.region, e.region);
      end
    end
  end

  // build an increasing table of n points with random y values
  task automatic fill_table(input int n, input int spread);
    plti_pkg::in_item_t it;
    int xs;
    xs = $urandom_range(1, 2000);
    for (int i = 0; i < n; i++) begin
      it = '0;
      it.op = plti_pkg::OP_LOAD;
      it.entry_index = i;
      it.x_value = xs;
      it.y_value = $urandom_range(0, 3) == 0 ? $urandom :
                   $signed($urandom_range(0, 2 * spread)) - spread;
      send_item(it, 1'b0, '0);
      xs = xs + $urandom_range(1, 1 << $urandom_range(0, 24));
      if (xs < 0 || xs > 32'h7000_0000) xs = 32'h7000_0000 + i;
    end
  endtask

  function automatic plti_pkg::in_item_t rand_item();
    plti_pkg::in_item_t it;
    int n;
    n = live_count();
    it.op = ($urandom_range(0, 9) < 8) ? plti_pkg::OP_LOOKUP : plti_pkg::OP_LOAD;
    it.x_value = $urandom;
    it.y_value = $urandom;
    it.entry_index = $urandom;
    if (it.op == plti_pkg::OP_LOOKUP) begin
      if ($urandom_range(0, 2) != 0)
        it.x_value = tab_x[0] + $signed($urandom_range(0, 1 << 20)) - 100;
      if ($urandom_range(0, 9) == 0)
        it.x_value = tab_x[n - 1] + $signed($urandom_range(0, 200)) - 100;
    end else begin
      // loads that may hit an unwritten predecessor are kept to safe indexes
      if (it.entry_index < n && it.entry_index > 0 && !written[it.entry_index - 1])
        it.entry_index = n;
      if (it.entry_index >= n && $urandom_range(0, 1) == 0 && it.entry_index > 0 &&
          written[it.entry_index - 1])
        it.x_value = tab_x[it.entry_index - 1] + $urandom_range(0, 3);
    end
    return it;
  endfunction

  typedef struct {
    plti_pkg::in_item_t it;
    bit has_want;
    plti_pkg::out_item_t want;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    plti_pkg::in_item_t it;
    int counts[5];
    int n;
    counts = '{2, 64, 5, 17, 33};
    cnt_reg = 2;
    floor_reg = 0;
    below_reg = 0;
    above_reg = 0;
    for (int i = 0; i < plti_pkg::TABLE_DEPTH; i++) begin
      tab_x[i] = 0;
      tab_y[i] = 0;
      written[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: load errors in check order, extremes, then lookups
    rows.push_back('{'{plti_pkg::OP_LOAD, 6'd2, 32'sd5, 32'sd1}, 1,
                     '{32'sd0, plti_pkg::ST_IDX_RANGE, plti_pkg::RG_INSIDE}});
    rows.push_back('{'{plti_pkg::OP_LOAD, 6'd63, -32'sd5, 32'sd1}, 1,
                     '{32'sd0, plti_pkg::ST_IDX_RANGE, plti_pkg::RG_INSIDE}});
    rows.push_back('{'{plti_pkg::OP_LOAD, 6'd0, 32'sd0, 32'sd1}, 1,
                     '{32'sd0, plti_pkg::ST_NOT_POS, plti_pkg::RG_INSIDE}});
    rows.push_back('{'{plti_pkg::OP_LOAD, 6'd0, 32'h8000_0000, 32'sd1}, 1,
                     '{32'sd0, plti_pkg::ST_NOT_POS, plti_pkg::RG_INSIDE}});
    rows.push_back('{'{plti_pkg::OP_LOAD, 6'd0, 32'sd256, 32'h8000_0000}, 1,
                     '{32'sd0, plti_pkg::ST_OK, plti_pkg::RG_INSIDE}});
    rows.push_back('{'{plti_pkg::OP_LOAD, 6'd1, 32'sd256, 32'sd1}, 1,
                     '{32'sd0, plti_pkg::ST_NOT_INCR, plti_pkg::RG_INSIDE}});
    rows.push_back('{'{plti_pkg::OP_LOAD, 6'd1, 32'h7fff_ffff, 32'h7fff_ffff}, 1,
                     '{32'sd0, plti_pkg::ST_OK, plti_pkg::RG_INSIDE}});
    // first y was floored to zero
    rows.push_back('{'{plti_pkg::OP_LOOKUP, 6'd0, 32'h8000_0000, 32'sd0}, 1,
                     '{32'sd0, plti_pkg::ST_OK, plti_pkg::RG_BELOW}});
    rows.push_back('{'{plti_pkg::OP_LOOKUP, 6'd0, 32'h7fff_ffff, 32'hffff_ffff}, 1,
                     '{32'h7fff_ffff, plti_pkg::ST_OK, plti_pkg::RG_ABOVE}});
    rows.push_back('{'{plti_pkg::OP_LOOKUP, 6'd63, 32'sd257, 32'sd0}, 0, '0});
    rows.push_back('{'{plti_pkg::OP_LOOKUP, 6'd0, 32'h4000_0000, 32'sd0}, 0, '0});
    foreach (rows[i]) send_item(rows[i].it, rows[i].has_want, rows[i].want);
    drain();

    // negative floor, zero modes and clamp, across table sizes
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(plti_pkg::CFG_ENTRY_COUNT,
                (ph == 0) ? 7'd0 : (ph == 1) ? 7'd127 : counts[ph]);
      write_reg(plti_pkg::CFG_OMEGA_MIN,
                (ph == 1) ? 32'h8000_0000 : (ph == 4) ? 32'h7fff_ffff :
                $signed($urandom_range(0, 1 << 20)) - (1 << 19));
      write_reg(plti_pkg::CFG_BELOW_ZERO, ph[0]);
      write_reg(plti_pkg::CFG_ABOVE_ZERO, ph[1]);
      n = live_count();
      for (int i = 0; i < plti_pkg::TABLE_DEPTH; i++) written[i] = (i < 2) ? written[i] : 0;
      fill_table(n, 1 << $urandom_range(4, 30));
      if (ph == 2) begin
        // receiver stalls long while the sender keeps offering items
        hold_off = 1'b1;
        for (int k = 0; k < 6; k++) send_item(rand_item(), 1'b0, '0);
        hold_off = 1'b0;
      end
      for (int k = 0; k < 80; k++) send_item(rand_item(), 1'b0, '0);
      drain();
    end

    drain();
    if (n_mismatch == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
